// ----- design/polled_tick_and_cpu_load_meter_top_assert.svh -----
// assertion macros for the polled tick and cpu load meter
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef POLLED_TICK_AND_CPU_LOAD_METER_TOP_ASSERT_SVH
`define POLLED_TICK_AND_CPU_LOAD_METER_TOP_ASSERT_SVH

// same-cycle implication
`define PLMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/plmt_pkg.sv -----
// shared types and constants for the polled tick and cpu load meter
// no dependencies
package plmt_pkg;

  localparam int unsigned PCT_W = 7;
  localparam int unsigned SUB_W = 14;
  localparam int unsigned CNT_W = 64;

  // scale factor of the share, walked msb first by the divider
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // quotient handed back by the divider
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } div_res_t;

endpackage

// ----- design/plmt_share_div.sv -----
// iterative scaled share divider: floor(part * 100 / whole), one add/compare per cycle
// depends on plmt_pkg
module plmt_share_div #(
  parameter int unsigned W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     part_i,
  input  logic [W-1:0]     whole_i,
  output plmt_pkg::div_res_t res_o
);

  logic [W-1:0]                 part_q, whole_q, rem_q;
  logic [plmt_pkg::PCT_W-1:0]   quo_q;
  logic [2:0]                   bit_q;
  logic                         phase_q;   // 0: doubling step, 1: add part step
  logic                         busy_q, done_q;

  logic [W:0]   sum;
  logic [W-1:0] nrem;
  logic [W-1:0] addend;
  logic         ge;

  // the shared unit: one add, one compare, one subtract
  // remainder stays below whole, so the reduced sum always fits in W bits
  assign addend = phase_q ? part_q : rem_q;
  assign sum    = {1'b0, rem_q} + {1'b0, addend};
  assign ge     = sum >= {1'b0, whole_q};
  assign nrem   = ge ? (sum[W-1:0] - whole_q) : sum[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        bit_q   <= 3'(plmt_pkg::PCT_W - 1);
      end else if (busy_q) begin
        if (!phase_q && plmt_pkg::PCT_MAX[bit_q]) begin
          phase_q <= 1'b1;
        end else if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          bit_q   <= bit_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      part_q  <= part_i;
      whole_q <= whole_i;
      rem_q   <= '0;
      quo_q   <= '0;
    end else if (busy_q) begin
      rem_q <= nrem;
      if (!phase_q) begin
        quo_q <= {quo_q[plmt_pkg::PCT_W-2:0], ge};
      end else begin
        quo_q <= quo_q + {{(plmt_pkg::PCT_W-1){1'b0}}, ge};
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.pct  = quo_q;

endmodule

// ----- design/polled_tick_and_cpu_load_meter_top.sv -----
// polled tick detector and cpu load meter, top level
// depends on plmt_pkg, plmt_share_div and polled_tick_and_cpu_load_meter_top_assert.svh
//
// channel   dir  tdata                                             tuser
// s_axis    in   [15:0] count_sample                               idle_poll
// m_axis    out  [63:0] tick_count, [127:64] seconds_count,        tick_seen
//                [134:128] busy_percent, [135] zero
//
// a poll without a tick goes through accept, then load of the output register
// a poll with a tick goes through accept, the share divider and the output load;
//   the divider runs 10 add/compare steps (7 doubling, 3 add for the set bits of 100)
// reset is asynchronous; no clearing pass, the block is ready right after reset
// input is taken whenever the sequencer is idle, even with a result still held;
//   the sequencer then waits at its output step until the held result is taken
`include "polled_tick_and_cpu_load_meter_top_assert.svh"

module polled_tick_and_cpu_load_meter_top #(
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned WINDOW_BITS      = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [15:0] count_sample
  input  logic         s_axis_tuser_i,   // idle_poll
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // tick_count, seconds_count, busy_percent, pad
  output logic         m_axis_tuser_o    // tick_seen
);

  localparam int unsigned W    = WINDOW_BITS;
  localparam int unsigned SW   = plmt_pkg::SUB_W;
  localparam int unsigned PW   = plmt_pkg::PCT_W;
  localparam int unsigned CW   = plmt_pkg::CNT_W;
  localparam logic [SW:0] TPS  = (SW+1)'(TICKS_PER_SECOND);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  // block state
  logic [15:0]   prev_q;
  logic [CW-1:0] ticks_q, secs_q;
  logic [SW-1:0] subsec_q;
  logic [W-1:0]  idle_win_q, polls_win_q;
  logic [PW-1:0] load_q;
  logic          tick_q;

  // output register
  logic          out_valid_q;
  logic [CW-1:0] out_ticks_q, out_secs_q;
  logic [PW-1:0] out_load_q;
  logic          out_tick_q;

  logic          accept, tick;
  logic [W-1:0]  polls_n, idle_inc, idle_n;
  logic [SW:0]   subsec_inc;
  logic          out_free;
  logic [PW-1:0] pct_clamped;

  plmt_pkg::div_res_t div_res;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // a wrap of the down-counter shows as a larger sample
  assign tick = s_axis_tdata_i > prev_q;

  // saturating window counts, current poll included
  assign polls_n  = (polls_win_q == '1) ? polls_win_q : polls_win_q + W'(1);
  assign idle_inc = (s_axis_tuser_i && idle_win_q != '1) ? idle_win_q + W'(1) : idle_win_q;
  assign idle_n   = (idle_inc > polls_n) ? polls_n : idle_inc;

  assign subsec_inc = {1'b0, subsec_q} + (SW+1)'(1);

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign pct_clamped = (div_res.pct > plmt_pkg::PCT_MAX) ? plmt_pkg::PCT_MAX : div_res.pct;

  // the divider copies the closed window at the tick
  plmt_share_div #(
    .W (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && tick),
    .part_i  (idle_n),
    .whole_i (polls_n),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= 16'hFFFF;
      ticks_q     <= '0;
      secs_q      <= '0;
      subsec_q    <= '0;
      idle_win_q  <= '0;
      polls_win_q <= '0;
      load_q      <= '0;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_ticks_q <= '0;
      out_secs_q  <= '0;
      out_load_q  <= '0;
      out_tick_q  <= 1'b0;
    end else begin
      // result register: loaded at the output step, emptied once taken
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        out_ticks_q <= ticks_q;
        out_secs_q  <= secs_q;
        out_load_q  <= load_q;
        out_tick_q  <= tick_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            prev_q <= s_axis_tdata_i;
            tick_q <= tick;
            if (tick) begin
              ticks_q     <= ticks_q + CW'(1);
              idle_win_q  <= '0;
              polls_win_q <= '0;
              if (subsec_inc >= TPS) begin
                subsec_q <= '0;
                secs_q   <= secs_q + CW'(1);
              end else begin
                subsec_q <= subsec_inc[SW-1:0];
              end
              state_q <= ST_DIV;
            end else begin
              idle_win_q  <= idle_n;
              polls_win_q <= polls_n;
              state_q     <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            load_q  <= plmt_pkg::PCT_MAX - pct_clamped;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_load_q, out_secs_q, out_ticks_q};
  assign m_axis_tuser_o  = out_tick_q;

  `PLMT_ASSERT_NOW(a_idle_le_polls, 1'b1, idle_win_q <= polls_win_q,
                   "idle count above poll count")
  `PLMT_ASSERT_NOW(a_subsec_range, 1'b1, {1'b0, subsec_q} < TPS,
                   "sub-second tick count out of range")
  `PLMT_ASSERT_NOW(a_done_in_div, div_res.done, state_q == ST_DIV,
                   "divider finished outside the divide step")
  `PLMT_ASSERT_NEXT(a_tick_starts_div, accept && tick, state_q == ST_DIV && polls_win_q == '0,
                    "tick did not start the divider and clear the window")

endmodule
